### design/tlw_pkg.sv
`timescale 1ns / 1ps

package tlw_pkg;

    localparam int OFF_W         = 32;
    localparam int COL_W         = 10;
    localparam int TAB_STOP      = 8;   // power of two
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW       = FIFO_AW + 1;

    localparam logic [COL_W-1:0] COLUMNS_RESET = COL_W'(80);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_END  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        TERM_NONE = 2'd0,
        TERM_CR   = 2'd1,
        TERM_LF   = 2'd2
    } t_term;

    typedef struct packed {
        logic [OFF_W-1:0] line_begin;
        logic [OFF_W-1:0] line_length;
        logic             final_line;
        logic             end_of_run;
    } t_rec;

    // cell count that the break test sees: count + 1, rounded up to a tab stop for a tab
    function automatic logic [COL_W+1:0] cell_span(input logic [COL_W-1:0] cnt,
                                                   input logic tab);
        logic [COL_W+1:0] n;
        n = {2'b00, cnt} + (COL_W+2)'(1);
        if (tab) begin
            n = (n + (COL_W+2)'(TAB_STOP - 1)) & ~((COL_W+2)'(TAB_STOP - 1));
        end
        return n;
    endfunction

endpackage

### design/text_line_wrapper_unit.sv
`timescale 1ns / 1ps
// Greedy text line wrapper.
// Input channel (i_valid / o_stall): one beat per text byte (i_opcode = byte) or
// one end-of-text beat (i_opcode = end). A beat is taken when i_valid is high and
// o_stall is low.
// Output channel (o_valid / i_stall): one beat per finished line record
// (start offset, length, final_line, end_of_run). end_of_run marks the last
// record caused by one input beat.
// Config channel (i_cfg_valid / o_cfg_ready): writes the column count; always
// ready. Write only while the block is idle.
// A taken input beat is registered; its records are then written to the record queue, whose head drives the output.
// Throughput: one input beat per cycle while the record queue can take two more
// records. A byte that breaks twice (space break then hard break) yields two
// records; a four-entry record queue absorbs these, and input stalls only when
// the queue cannot take two more records.
// Stall: i_stall holds the head record; once the queue is near full, o_stall rises.
// Reset (synchronous, active low): offsets, counters and the queue clear, column
// count returns to 80.
module text_line_wrapper_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_opcode,
    input  logic [7:0]                i_text_byte,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [tlw_pkg::OFF_W-1:0] o_line_begin,
    output logic [tlw_pkg::OFF_W-1:0] o_line_length,
    output logic                      o_final_line,
    output logic                      o_end_of_run,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [tlw_pkg::COL_W-1:0] i_columns
);
    import tlw_pkg::*;

    logic               r_in_vld;
    logic               r_in_op;
    logic [7:0]         r_in_byte;

    logic [COL_W-1:0]   r_columns;
    logic [OFF_W-1:0]   r_pos,   n_pos;
    logic [OFF_W-1:0]   r_start, n_start;
    logic [COL_W-1:0]   r_cc,    n_cc;
    logic [OFF_W-1:0]   r_sp,    n_sp;
    t_term              r_pend,  n_pend;

    t_rec               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_cnt;

    logic               go;
    logic               in_take;
    logic               pop;
    logic [1:0]         n_push;
    t_rec               rec0;
    t_rec               rec1;

    logic               is_tab;
    logic               is_cr;
    logic               is_lf;
    logic               is_space;
    logic [OFF_W-1:0]   k;
    logic               k_over;

    assign o_cfg_ready = 1'b1;

    assign go      = r_in_vld && (r_cnt <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_stall = r_in_vld && !go;
    assign in_take = i_valid && !o_stall;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;

    assign o_line_begin  = r_fifo[r_rd_ptr].line_begin;
    assign o_line_length = r_fifo[r_rd_ptr].line_length;
    assign o_final_line  = r_fifo[r_rd_ptr].final_line;
    assign o_end_of_run  = r_fifo[r_rd_ptr].end_of_run;

    assign is_tab   = (r_in_byte == CH_TAB);
    assign is_cr    = (r_in_byte == CH_CR);
    assign is_lf    = (r_in_byte == CH_LF);
    assign is_space = (r_in_byte == CH_SPACE);

    // bytes of the open line after a space break, before this byte: pos - (sp + 1)
    assign k      = r_pos + ~r_sp;
    assign k_over = (|k[OFF_W-1:COL_W]) ||
                    (cell_span(k[COL_W-1:0], is_tab) >= {2'b00, r_columns});

    always_comb begin
        n_pos   = r_pos;
        n_start = r_start;
        n_cc    = r_cc;
        n_sp    = r_sp;
        n_pend  = r_pend;
        n_push  = 2'd0;
        rec0    = '{line_begin: r_start, line_length: r_pos - r_start,
                    final_line: 1'b0, end_of_run: 1'b1};
        rec1    = '{line_begin: r_sp + OFF_W'(1), line_length: k,
                    final_line: 1'b0, end_of_run: 1'b1};
        if (r_in_op == OP_END) begin
            rec0.final_line = 1'b1;
            n_push  = 2'd1;
            n_pos   = '0;
            n_start = '0;
            n_cc    = '0;
            n_sp    = '0;
            n_pend  = TERM_NONE;
        end else if ((r_pend == TERM_CR && is_lf) || (r_pend == TERM_LF && is_cr)) begin
            // pair partner: swallowed
            n_pend  = TERM_NONE;
            n_pos   = r_pos + OFF_W'(1);
            n_start = r_pos + OFF_W'(1);
        end else begin
            n_pend = TERM_NONE;
            n_pos  = r_pos + OFF_W'(1);
            if (is_cr || is_lf) begin
                n_push  = 2'd1;
                n_start = r_pos + OFF_W'(1);
                n_cc    = '0;
                n_sp    = '0;
                n_pend  = is_cr ? TERM_CR : TERM_LF;
            end else if (cell_span(r_cc, is_tab) >= {2'b00, r_columns}) begin
                if (r_sp != '0) begin
                    rec0.line_length = r_sp + OFF_W'(1) - r_start;
                    n_sp = '0;
                    if (k_over) begin
                        rec0.end_of_run = 1'b0;
                        n_push  = 2'd2;
                        n_start = r_pos + OFF_W'(1);
                        n_cc    = '0;
                    end else begin
                        n_push  = 2'd1;
                        n_start = r_sp + OFF_W'(1);
                        n_cc    = k[COL_W-1:0] + COL_W'(1);
                        if (is_space) begin
                            n_sp = r_pos;
                        end
                    end
                end else begin
                    // hard break, byte dropped
                    n_push  = 2'd1;
                    n_start = r_pos + OFF_W'(1);
                    n_cc    = '0;
                end
            end else begin
                n_cc = r_cc + COL_W'(1);
                if (is_space) begin
                    n_sp = r_pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_columns <= COLUMNS_RESET;
            r_pos     <= '0;
            r_start   <= '0;
            r_cc      <= '0;
            r_sp      <= '0;
            r_pend    <= TERM_NONE;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_columns <= i_columns;
            end
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (go) begin
                r_in_vld <= 1'b0;
            end
            if (go) begin
                r_pos    <= n_pos;
                r_start  <= n_start;
                r_cc     <= n_cc;
                r_sp     <= n_sp;
                r_pend   <= n_pend;
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(n_push);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_cnt <= r_cnt + (go ? FIFO_CW'(n_push) : FIFO_CW'(0))
                           - (pop ? FIFO_CW'(1) : FIFO_CW'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op   <= i_opcode;
            r_in_byte <= i_text_byte;
        end
        if (go && n_push != 2'd0) begin
            r_fifo[r_wr_ptr] <= rec0;
        end
        if (go && n_push == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= rec1;
        end
    end

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FIFO_CW'(FIFO_DEPTH))
        else $error("record queue overflow");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && r_in_op == OP_END) |=> (r_pos == '0 && r_start == '0 && r_pend == TERM_NONE))
        else $error("end of text did not clear text state");

    a_double_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && n_push == 2'd2) |-> (!rec0.end_of_run && rec1.end_of_run))
        else $error("double break marks wrong end_of_run");

    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != TERM_NONE) |-> (r_cc == '0 && r_sp == '0))
        else $error("open line not empty after terminator");

endmodule
